@@ rtl/core/hms_pkg.sv @@
// ----------------------------------------------------------------------------
// hms_pkg
// constants, marker tables and helpers for the html markup stripper
// ----------------------------------------------------------------------------
package hms_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned VIEW_LEN = 9;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned NUM_MARK = 8;

    localparam logic [CHAR_W-1:0] CHAR_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CHAR_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [CNT_W-1:0] VIEW_FULL = CNT_W'(VIEW_LEN);

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [0:VIEW_LEN-1][CHAR_W-1:0] mark_text_t;

    typedef enum logic [1:0]
    {
        MK_SCRIPT_OPEN,
        MK_SCRIPT_CLOSE,
        MK_STYLE_OPEN,
        MK_STYLE_CLOSE
    } mark_kind_t;

    // markers in priority order, first byte at index 0, zero padded
    localparam mark_text_t MARK_TEXT [NUM_MARK] = '{
        {"<script>", 8'h00},
        {"<SCRIPT>", 8'h00},
        "</script>",
        "</SCRIPT>",
        {"<style>", 16'h0000},
        {"<STYLE>", 16'h0000},
        {"</style>", 8'h00},
        {"</STYLE>", 8'h00}
    };

    localparam logic [CNT_W-1:0] MARK_LEN [NUM_MARK] = '{
        4'd8, 4'd8, 4'd9, 4'd9, 4'd7, 4'd7, 4'd8, 4'd8
    };

    localparam mark_kind_t MARK_KIND [NUM_MARK] = '{
        MK_SCRIPT_OPEN, MK_SCRIPT_OPEN, MK_SCRIPT_CLOSE, MK_SCRIPT_CLOSE,
        MK_STYLE_OPEN, MK_STYLE_OPEN, MK_STYLE_CLOSE, MK_STYLE_CLOSE
    };

    function automatic logic is_ws(input char_t c);
        logic r;
        r = c inside {[8'd9:8'd13], CHAR_SPACE};
        return r;
    endfunction

endpackage

@@ rtl/core/html_markup_stripper_top.sv @@
// ----------------------------------------------------------------------------
// html_markup_stripper_top
// streaming html text extractor with a nine-byte marker window
// ----------------------------------------------------------------------------
// Takes one document byte per transaction and returns cleaned text bytes, one
// per transaction. The block holds a nine-byte window; once it is full, the
// head byte is classified against the script/style markers and the tag and
// whitespace rules at one byte per cycle while input arrives and the output
// is not stalled; a text byte leaves once eight later bytes have entered, or
// in the flush. A transaction with tlast starts a flush: input is held off
// while the remaining window bytes are processed one per cycle when the output
// is free, then one end marker with tlast high and tuser low is sent, after
// which the next byte begins a new document. Back pressure on the output
// stalls head-byte steps and the end marker; bytes enter while there is room.
// ----------------------------------------------------------------------------
module html_markup_stripper_top
    import hms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,   // in_char
    input  logic              s_axis_tlast,   // doc_end
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [CHAR_W-1:0] m_axis_tdata,   // out_char
    output logic              m_axis_tuser,   // has_char
    output logic              m_axis_tlast    // doc_done
);

    char_t            win_reg [VIEW_LEN];
    char_t            win_next [VIEW_LEN];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] skip_reg, skip_next;
    logic             flush_reg, flush_next;
    logic             tag_reg, tag_next;
    logic             script_reg, script_next;
    logic             style_reg, style_next;
    logic             lws_reg, lws_next;
    logic             wrote_reg, wrote_next;

    logic             out_valid_reg, out_valid_next;
    char_t            out_char_reg, out_char_next;
    logic             out_has_reg, out_has_next;
    logic             out_done_reg, out_done_next;

    logic             out_free;
    logic             proc_go;
    logic             end_go;
    logic             in_go;
    logic             hit;
    mark_kind_t       hit_kind;
    logic [CNT_W-1:0] hit_len;
    logic [CNT_W-1:0] cnt_after;
    char_t            head;
    logic             emit;
    logic             emit_space;
    char_t            emit_char;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign proc_go  = out_free && (count_reg != '0)
                      && ((count_reg == VIEW_FULL) || flush_reg);
    assign end_go   = out_free && flush_reg && (count_reg == '0);
    assign s_axis_tready = !flush_reg && ((count_reg != VIEW_FULL) || proc_go);
    assign in_go    = s_axis_tvalid && s_axis_tready;
    assign head     = win_reg[0];

    // marker search on the window head
    always_comb
    begin
        logic eq;
        hit      = 1'b0;
        hit_kind = MK_SCRIPT_OPEN;
        hit_len  = '0;
        for (int m = 0; m < NUM_MARK; m++)
        begin
            eq = (count_reg >= MARK_LEN[m]);
            for (int j = 0; j < VIEW_LEN; j++)
            begin
                if (CNT_W'(j) < MARK_LEN[m] && win_reg[j] != MARK_TEXT[m][j])
                begin
                    eq = 1'b0;
                end
            end
            if (eq && !hit)
            begin
                hit      = 1'b1;
                hit_kind = MARK_KIND[m];
                hit_len  = MARK_LEN[m];
            end
        end
    end

    always_comb
    begin
        skip_next   = skip_reg;
        tag_next    = tag_reg;
        script_next = script_reg;
        style_next  = style_reg;
        lws_next    = lws_reg;
        wrote_next  = wrote_reg;
        flush_next  = flush_reg;
        emit        = 1'b0;
        emit_space  = 1'b0;
        emit_char   = head;

        if (proc_go)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - 1'b1;
            end
            else if (hit)
            begin
                case (hit_kind)
                    MK_SCRIPT_OPEN:  script_next = 1'b1;
                    MK_SCRIPT_CLOSE: script_next = 1'b0;
                    MK_STYLE_OPEN:   style_next  = 1'b1;
                    MK_STYLE_CLOSE:  style_next  = 1'b0;
                    default:         script_next = script_reg;
                endcase
                emit_space = 1'b1;
                skip_next  = hit_len - 1'b1;
            end
            else if (script_reg || style_reg)
            begin
                emit = 1'b0;
            end
            else if (head == CHAR_LT)
            begin
                tag_next   = 1'b1;
                emit_space = 1'b1;
            end
            else if (head == CHAR_GT)
            begin
                tag_next   = 1'b0;
                emit_space = 1'b1;
            end
            else if (tag_reg)
            begin
                emit = 1'b0;
            end
            else if (is_ws(head))
            begin
                emit_space = 1'b1;
            end
            else
            begin
                emit       = 1'b1;
                wrote_next = 1'b1;
                lws_next   = 1'b0;
            end

            if (emit_space && wrote_reg && !lws_reg)
            begin
                emit      = 1'b1;
                emit_char = CHAR_SPACE;
                lws_next  = 1'b1;
            end
        end

        if (end_go)
        begin
            skip_next   = '0;
            tag_next    = 1'b0;
            script_next = 1'b0;
            style_next  = 1'b0;
            lws_next    = 1'b0;
            wrote_next  = 1'b0;
            flush_next  = 1'b0;
        end
        else if (in_go && s_axis_tlast)
        begin
            flush_next = 1'b1;
        end
    end

    // window shift and append
    always_comb
    begin
        cnt_after = count_reg - CNT_W'(proc_go);
        for (int i = 0; i < VIEW_LEN; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (proc_go)
        begin
            for (int i = 0; i < VIEW_LEN - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
        end
        if (in_go)
        begin
            win_next[cnt_after] = s_axis_tdata;
        end
        count_next = cnt_after + CNT_W'(in_go);
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_has_next   = out_has_reg;
        out_done_next  = out_done_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_has_next   = 1'b1;
            out_done_next  = 1'b0;
        end
        else if (end_go)
        begin
            out_valid_next = 1'b1;
            out_char_next  = CHAR_NUL;
            out_has_next   = 1'b0;
            out_done_next  = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            skip_reg      <= '0;
            flush_reg     <= 1'b0;
            tag_reg       <= 1'b0;
            script_reg    <= 1'b0;
            style_reg     <= 1'b0;
            lws_reg       <= 1'b0;
            wrote_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            skip_reg      <= skip_next;
            flush_reg     <= flush_next;
            tag_reg       <= tag_next;
            script_reg    <= script_next;
            style_reg     <= style_next;
            lws_reg       <= lws_next;
            wrote_reg     <= wrote_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < VIEW_LEN; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        out_char_reg <= out_char_next;
        out_has_reg  <= out_has_next;
        out_done_reg <= out_done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tuser  = out_has_reg;
    assign m_axis_tlast  = out_done_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= VIEW_FULL)
        else $error("window count out of range");

    a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg < VIEW_FULL)
        else $error("skip count out of range");

    a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> !s_axis_tready)
        else $error("input taken during flush");

    a_end_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tuser && m_axis_tdata == CHAR_NUL))
        else $error("malformed end marker");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        end_go |=> (!flush_reg && !wrote_reg && !tag_reg && !script_reg && !style_reg))
        else $error("state not cleared after end marker");
`endif

endmodule

@@ tb/tb_html_markup_stripper_top.sv @@
// ----------------------------------------------------------------------------
// tb_html_markup_stripper_top
// streaming check of the html markup stripper against a cycle-free predictor
// ----------------------------------------------------------------------------
// Feeds short html-like documents byte by byte: a few hand-built ones that hit
// the byte extremes, whitespace-only and marker cases, then random documents
// made of text, whitespace, tags, exact and broken script/style markers and
// arbitrary bytes. Every accepted byte goes into a predictor that produces
// the cleaned text bytes and the end marker; every output transaction is
// compared against the oldest prediction. Both sides stall at random, but for a quiet stretch.
// ----------------------------------------------------------------------------
module tb_html_markup_stripper_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hms_pkg::*;

    class text_predictor;
        typedef struct
        {
            char_t ch;
            logic  has;
            logic  done;
        } text_result_t;

        static string marker_text [8] = '{
            "<script>", "<SCRIPT>", "</script>", "</SCRIPT>",
            "<style>", "<STYLE>", "</style>", "</STYLE>"
        };

        char_t        window [8];
        char_t        view [VIEW_LEN];
        int unsigned  fill;
        int unsigned  skip;
        bit           in_tag;
        bit           script_on;
        bit           style_on;
        bit           last_space;
        bit           wrote;
        text_result_t expected_text [$];
        int           errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            fill       = 0;
            skip       = 0;
            in_tag     = 0;
            script_on  = 0;
            style_on   = 0;
            last_space = 0;
            wrote      = 0;
        endfunction

        function void push_result(char_t ch, logic has, logic done);
            text_result_t r;
            r.ch   = ch;
            r.has  = has;
            r.done = done;
            expected_text.push_back(r);
        endfunction

        function void put_space();
            if (wrote && !last_space)
            begin
                push_result(CHAR_SPACE, 1'b1, 1'b0);
                last_space = 1;
            end
        endfunction

        // one byte of the view, with avail document bytes from pos on
        function void strip_byte(int unsigned pos, int unsigned avail);
            int unsigned len;
            bit          hit;
            char_t       c;
            if (skip > 0)
            begin
                skip--;
                return;
            end
            for (int m = 0; m < 8; m++)
            begin
                len = marker_text[m].len();
                if (avail < len || pos + len > VIEW_LEN)
                    continue;
                hit = 1;
                for (int j = 0; j < len; j++)
                    if (view[pos + j] != char_t'(marker_text[m][j]))
                        hit = 0;
                if (!hit)
                    continue;
                case (mark_kind_t'(m / 2))
                    MK_SCRIPT_OPEN:  script_on = 1;
                    MK_SCRIPT_CLOSE: script_on = 0;
                    MK_STYLE_OPEN:   style_on = 1;
                    default:         style_on = 0;
                endcase
                put_space();
                skip = len - 1;
                return;
            end
            if (script_on || style_on)
                return;
            c = view[pos];
            if (c == CHAR_LT)
            begin
                in_tag = 1;
                put_space();
            end
            else if (c == CHAR_GT)
            begin
                in_tag = 0;
                put_space();
            end
            else if (!in_tag)
            begin
                if (c == CHAR_SPACE || (c >= 8'd9 && c <= 8'd13))
                    put_space();
                else
                begin
                    push_result(c, 1'b1, 1'b0);
                    wrote      = 1;
                    last_space = 0;
                end
            end
        endfunction

        function void take_byte(char_t ch, logic last);
            int unsigned total;
            for (int k = 0; k < fill; k++)
                view[k] = window[k];
            view[fill] = ch;
            total = fill + 1;
            if (last)
            begin
                for (int k = 0; k < total; k++)
                    strip_byte(k, total - k);
                push_result(CHAR_NUL, 1'b0, 1'b1);
                clear();
            end
            else if (total == VIEW_LEN)
            begin
                strip_byte(0, VIEW_LEN);
                for (int k = 0; k < 8; k++)
                    window[k] = view[k + 1];
                fill = 8;
            end
            else
            begin
                for (int k = 0; k < total; k++)
                    window[k] = view[k];
                fill = total;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_output(char_t ch, logic has, logic done);
            text_result_t want;
            if (expected_text.size() == 0)
            begin
                report($sformatf("unexpected transaction data %h user %b last %b",
                                 ch, has, done));
                return;
            end
            want = expected_text.pop_front();
            if (want.ch !== ch || want.has !== has || want.done !== done)
                report($sformatf("got data %h user %b last %b, want %h %b %b",
                                 ch, has, done, want.ch, want.has, want.done));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [CHAR_W-1:0] s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [CHAR_W-1:0] m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;

    text_predictor board = new();
    char_t         doc_bytes [$];
    bit            quiet;

    html_markup_stripper_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb_html_markup_stripper_top: done, errors");
        $finish;
    end

    // output side, random back pressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= rst_n && (quiet || $urandom_range(99) >= 12);
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task send_byte(char_t ch, logic last);
        while (!quiet && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.take_byte(ch, last);
        @(negedge clk);
    endtask

    task send_doc();
        if (doc_bytes.size() == 0)
            doc_bytes.push_back(8'h78);
        for (int i = 0; i < doc_bytes.size(); i++)
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
        doc_bytes.delete();
    endtask

    task add_text(string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(char_t'(s[i]));
    endtask

    task build_random_doc();
        int unsigned tokens;
        int unsigned pick;
        int unsigned n;
        string       s;
        tokens = $urandom_range(1, 12);
        for (int t = 0; t < tokens; t++)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
            begin
                s = text_predictor::marker_text[$urandom_range(7)];
                n = $urandom_range(5);
                if (n == 0)
                    s = s.substr(0, $urandom_range(s.len() - 2));
                else if (n == 1)
                begin
                    n = $urandom_range(s.len() - 1);
                    s.putc(n, s[n] ^ 8'h20);
                end
                add_text(s);
            end
            else if (pick < 50)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    doc_bytes.push_back(char_t'($urandom_range(8'h21, 8'h7e)));
            end
            else if (pick < 70)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                begin
                    pick = $urandom_range(6);
                    doc_bytes.push_back(pick == 6 ? CHAR_SPACE : char_t'(8 + pick));
                end
            end
            else if (pick < 85)
            begin
                if ($urandom_range(7) != 0)
                    doc_bytes.push_back(CHAR_LT);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                    doc_bytes.push_back(char_t'($urandom_range(8'h61, 8'h7a)));
                if ($urandom_range(7) != 0)
                    doc_bytes.push_back(CHAR_GT);
            end
            else
                doc_bytes.push_back(char_t'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int unsigned sent;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // byte extremes, tab, text ending in a bracket
        doc_bytes = '{8'hFF, 8'h00, 8'h09, 8'h61, CHAR_GT};
        send_doc();
        // whitespace only, no leading space
        doc_bytes = '{CHAR_SPACE};
        send_doc();
        // style section, upper case markers
        add_text("<STYLE>q</STYLE>k");
        send_doc();
        // lone open bracket as the whole document
        doc_bytes = '{CHAR_LT};
        send_doc();

        sent = 0;
        while (sent < 410)
        begin
            quiet = (sent >= 150 && sent < 260);
            build_random_doc();
            sent += doc_bytes.size();
            send_doc();
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (board.expected_text.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("tb_html_markup_stripper_top: done, clean");
        else
            $display("tb_html_markup_stripper_top: done, errors");
        $finish;
    end
endmodule
